### src/dtsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsa_pkg
// Types, widths and constants for the decimal text sum accumulator.
// ----------------------------------------------------------------------------
package dtsa_pkg;

    localparam int CHAR_BITS   = 8;
    localparam int WHOLE_BITS  = 48;
    localparam int FRAC_BITS   = 34;
    localparam int FRAC_DIGITS = 10;
    localparam int CNT_BITS    = 4;

    localparam logic [WHOLE_BITS-1:0] WHOLE_MAX  = {WHOLE_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0]  FRAC_SCALE = 34'd10000000000;

    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_WHOLE  = 4'b0010,
        PH_FRAC   = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    // Finished value handed from the parser to the accumulator
    typedef struct packed {
        logic                  valid;
        logic                  send;
        logic                  ovf;
        logic [WHOLE_BITS-1:0] whole;
        logic [FRAC_BITS-1:0]  frac;
    } fin_t;

    // Place value of a fraction digit: 10^n for n = 0..9
    function automatic logic [FRAC_BITS-1:0] pow10_frac(input logic [CNT_BITS-1:0] n);
        logic [FRAC_BITS-1:0] p;
        begin
            unique case (n)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

endpackage
`default_nettype wire

### src/dtsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsa_in_if / dtsa_out_if
// Valid/ready channels for characters in and set totals out.
// ----------------------------------------------------------------------------
interface dtsa_in_if;
    logic                           valid;
    logic                           ready;
    logic [dtsa_pkg::CHAR_BITS-1:0] ch;
    logic                           value_end;
    logic                           set_end;

    modport source(output valid, output ch, output value_end, output set_end, input ready);
    modport sink(input valid, input ch, input value_end, input set_end, output ready);
endinterface

interface dtsa_out_if;
    logic                            valid;
    logic                            ready;
    logic [dtsa_pkg::WHOLE_BITS-1:0] total_whole;
    logic [dtsa_pkg::FRAC_BITS-1:0]  total_frac;
    logic                            saturated;

    modport source(output valid, output total_whole, output total_frac, output saturated,
                   input ready);
    modport sink(input valid, input total_whole, input total_frac, input saturated,
                 output ready);
endinterface
`default_nettype wire

### src/decimal_text_sum_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a set_end transaction, once accepted, is registered in the parse stage
//   (fin_reg), then the accumulate stage loads its total into the output register.
// Throughput: one character per cycle; ready drops only while a total waits at
//   the output register and the sink is not ready.
// Reset: rst_n clears parser state, running totals and all valid flags at once.
// ----------------------------------------------------------------------------
// decimal_text_sum_accumulator
// Parses decimal text one character per transaction into whole and ten-digit
// fraction parts, sums the values of a set and reports the total at set end.
// ----------------------------------------------------------------------------
module decimal_text_sum_accumulator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dtsa_in_if.sink    text,
    dtsa_out_if.source result
);
    import dtsa_pkg::*;

    // Parser state
    phase_t                phase_reg, phase_next;
    logic [WHOLE_BITS-1:0] vwhole_reg, vwhole_next;
    logic [FRAC_BITS-1:0]  vfrac_reg, vfrac_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  vovf_reg, vovf_next;

    // Stage between parser and accumulator
    fin_t fin_reg, fin_next;

    // Running totals
    logic [WHOLE_BITS-1:0] sum_whole_reg, sum_whole_next;
    logic [FRAC_BITS-1:0]  sum_frac_reg, sum_frac_next;
    logic                  sovf_reg, sovf_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [WHOLE_BITS-1:0] out_whole_reg, out_whole_next;
    logic [FRAC_BITS-1:0]  out_frac_reg, out_frac_next;
    logic                  out_sat_reg, out_sat_next;

    logic                  advance;
    logic                  accept;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  is_sign;
    phase_t                phase_eff;
    logic [WHOLE_BITS+3:0] whole_x10;
    logic                  whole_sat;
    logic [FRAC_BITS-1:0]  frac_term;
    logic [WHOLE_BITS+1:0] whole_sum;
    logic [FRAC_BITS:0]    frac_sum;
    logic                  frac_carry;
    logic [WHOLE_BITS-1:0] acc_whole;
    logic [FRAC_BITS-1:0]  acc_frac;
    logic                  acc_ovf;
    logic                  ends_value;

    // Pipeline moves whenever the output register is free or being drained
    assign advance    = !out_valid_reg || result.ready;
    assign text.ready = advance;
    assign accept     = text.valid && advance;

    // Character decode
    assign is_digit = (text.ch >= CH_ZERO) && (text.ch <= CH_NINE);
    assign digit    = is_digit ? 4'(text.ch - CH_ZERO) : 4'd0;
    assign is_sign  = (text.ch == CH_MINUS) || (text.ch == CH_PLUS);

    // Digit arithmetic: x10 + d with saturation; fraction digit at its place value
    assign whole_x10 = ({4'd0, vwhole_reg} << 3) + ({4'd0, vwhole_reg} << 1)
                     + {{WHOLE_BITS{1'b0}}, digit};
    assign whole_sat = whole_x10 > {4'd0, WHOLE_MAX};
    assign frac_term = FRAC_BITS'(pow10_frac(CNT_BITS'(FRAC_DIGITS - 1) - cnt_reg)
                                  * {{(FRAC_BITS-4){1'b0}}, digit});
    assign ends_value = text.value_end || text.set_end;

    // Parser: one character per transaction
    always_comb
    begin
        phase_next  = phase_reg;
        vwhole_next = vwhole_reg;
        vfrac_next  = vfrac_reg;
        cnt_next    = cnt_reg;
        vovf_next   = vovf_reg;
        phase_eff   = (phase_reg == PH_START) ? PH_WHOLE : phase_reg;

        if (phase_reg == PH_START && is_sign)
        begin
            phase_next = PH_WHOLE;
        end
        else
        begin
            unique case (phase_eff)
                PH_WHOLE:
                begin
                    phase_next = PH_WHOLE;
                    if (is_digit)
                    begin
                        if (whole_sat)
                        begin
                            vwhole_next = WHOLE_MAX;
                            vovf_next   = 1'b1;
                        end
                        else
                        begin
                            vwhole_next = whole_x10[WHOLE_BITS-1:0];
                        end
                    end
                    else if (text.ch == CH_POINT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_FRAC:
                begin
                    if (is_digit && (cnt_reg < CNT_BITS'(FRAC_DIGITS)))
                    begin
                        vfrac_next = vfrac_reg + frac_term;
                        cnt_next   = cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_IGNORE: phase_next = PH_IGNORE;
                default:   phase_next = PH_IGNORE;
            endcase
        end

        // Finished value goes to the accumulator stage
        fin_next.valid = accept && ends_value;
        fin_next.send  = text.set_end;
        fin_next.ovf   = vovf_next;
        fin_next.whole = vwhole_next;
        fin_next.frac  = vfrac_next;

        if (ends_value)
        begin
            phase_next  = PH_START;
            vwhole_next = '0;
            vfrac_next  = '0;
            cnt_next    = '0;
            vovf_next   = 1'b0;
        end
    end

    // Accumulate: whole plus fraction carry, one saturating add
    assign frac_sum   = {1'b0, sum_frac_reg} + {1'b0, fin_reg.frac};
    assign frac_carry = frac_sum >= {1'b0, FRAC_SCALE};
    assign acc_frac   = frac_carry ? FRAC_BITS'(frac_sum - {1'b0, FRAC_SCALE})
                                   : frac_sum[FRAC_BITS-1:0];
    assign whole_sum  = {2'd0, sum_whole_reg} + {2'd0, fin_reg.whole}
                      + {{(WHOLE_BITS+1){1'b0}}, frac_carry};
    assign acc_whole  = (whole_sum > {2'd0, WHOLE_MAX}) ? WHOLE_MAX
                                                        : whole_sum[WHOLE_BITS-1:0];
    assign acc_ovf    = sovf_reg || fin_reg.ovf || (whole_sum > {2'd0, WHOLE_MAX});

    always_comb
    begin
        sum_whole_next = sum_whole_reg;
        sum_frac_next  = sum_frac_reg;
        sovf_next      = sovf_reg;
        out_valid_next = out_valid_reg;
        out_whole_next = out_whole_reg;
        out_frac_next  = out_frac_reg;
        out_sat_next   = out_sat_reg;

        if (advance)
        begin
            out_valid_next = fin_reg.valid && fin_reg.send;
            if (fin_reg.valid)
            begin
                if (fin_reg.send)
                begin
                    out_whole_next = acc_whole;
                    out_frac_next  = acc_frac;
                    out_sat_next   = acc_ovf;
                    sum_whole_next = '0;
                    sum_frac_next  = '0;
                    sovf_next      = 1'b0;
                end
                else
                begin
                    sum_whole_next = acc_whole;
                    sum_frac_next  = acc_frac;
                    sovf_next      = acc_ovf;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            vwhole_reg    <= '0;
            vfrac_reg     <= '0;
            cnt_reg       <= '0;
            vovf_reg      <= 1'b0;
            fin_reg       <= '0;
            sum_whole_reg <= '0;
            sum_frac_reg  <= '0;
            sovf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                vwhole_reg <= vwhole_next;
                vfrac_reg  <= vfrac_next;
                cnt_reg    <= cnt_next;
                vovf_reg   <= vovf_next;
            end
            if (advance)
            begin
                fin_reg <= fin_next;
            end
            sum_whole_reg <= sum_whole_next;
            sum_frac_reg  <= sum_frac_next;
            sovf_reg      <= sovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_whole_reg <= out_whole_next;
        out_frac_reg  <= out_frac_next;
        out_sat_reg   <= out_sat_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.total_whole = out_whole_reg;
    assign result.total_frac  = out_frac_reg;
    assign result.saturated   = out_sat_reg;

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_text_sum_accumulator. Streams decimal text
// one character per transaction, predicts each set total, and compares every
// total the block returns, with random idling on both channels, a long output
// stall and drain pauses between phases.
// ----------------------------------------------------------------------------
module testbench;

    import dtsa_pkg::*;

    localparam logic [63:0] WHOLE_LIMIT = 64'(WHOLE_MAX);
    localparam int          HOLD_CYCLES = 200;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          TAIL_CYCLES = 6;
    localparam int          PRINT_CAP   = 50;

    typedef struct packed {
        logic [WHOLE_BITS-1:0] whole;
        logic [FRAC_BITS-1:0]  frac;
        logic                  sat;
    } set_total_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dtsa_in_if  text_if();
    dtsa_out_if result_if();

    decimal_text_sum_accumulator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    // Parser and running-total state of the predictor
    phase_t      scan_phase    = PH_START;
    logic [63:0] cur_whole     = '0;
    logic [63:0] cur_frac      = '0;
    int unsigned cur_frac_cnt  = 0;
    logic [63:0] run_whole     = '0;
    logic [63:0] run_frac      = '0;
    logic        run_sat       = 1'b0;

    set_total_t  totals_due[$];
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    int unsigned hold_requests   = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] ten_to(input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [63:0] add_whole_sat(input logic [63:0] a, input logic [63:0] b);
        if (a > WHOLE_LIMIT - b)
        begin
            run_sat = 1'b1;
            return WHOLE_LIMIT;
        end
        return a + b;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic        is_digit;
        logic [63:0] d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = is_digit ? 64'(c - CH_ZERO) : 64'd0;
        // A sign is skipped only as the first character
        if (scan_phase == PH_START)
        begin
            scan_phase = PH_WHOLE;
            if (c == CH_MINUS || c == CH_PLUS)
                return;
        end
        case (scan_phase)
            PH_WHOLE:
            begin
                if (is_digit)
                begin
                    if (cur_whole > (WHOLE_LIMIT - d) / 64'd10)
                    begin
                        cur_whole = WHOLE_LIMIT;
                        run_sat   = 1'b1;
                    end
                    else
                        cur_whole = cur_whole * 64'd10 + d;
                end
                else if (c == CH_POINT)
                    scan_phase = PH_FRAC;
                else
                    scan_phase = PH_IGNORE;
            end
            PH_FRAC:
            begin
                if (is_digit && cur_frac_cnt < FRAC_DIGITS)
                begin
                    cur_frac = cur_frac * 64'd10 + d;
                    cur_frac_cnt++;
                end
                else
                    scan_phase = PH_IGNORE;
            end
            default: ;
        endcase
    endfunction

    // Add the finished value into the set total, normalizing the fraction carry
    function automatic void fold_value();
        run_whole = add_whole_sat(run_whole, cur_whole);
        run_frac  = run_frac + cur_frac * ten_to(FRAC_DIGITS - cur_frac_cnt);
        if (run_frac >= ten_to(FRAC_DIGITS))
        begin
            run_frac  = run_frac - ten_to(FRAC_DIGITS);
            run_whole = add_whole_sat(run_whole, 64'd1);
        end
        scan_phase   = PH_START;
        cur_whole    = '0;
        cur_frac     = '0;
        cur_frac_cnt = 0;
    endfunction

    function automatic void predict_total(input logic [7:0] c, input logic ve, input logic se);
        set_total_t t;
        scan_char(c);
        if (ve || se)
            fold_value();
        if (se)
        begin
            t.whole = run_whole[WHOLE_BITS-1:0];
            t.frac  = run_frac[FRAC_BITS-1:0];
            t.sat   = run_sat;
            totals_due.push_back(t);
            run_whole = '0;
            run_frac  = '0;
            run_sat   = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_totals
        set_total_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (totals_due.size() == 0)
                report_mismatch("total with none pending", 64'd0,
                                64'(result_if.total_whole));
            else
            begin
                want = totals_due.pop_front();
                if (result_if.total_whole !== want.whole)
                    report_mismatch("total_whole", 64'(want.whole),
                                    64'(result_if.total_whole));
                if (result_if.total_frac !== want.frac)
                    report_mismatch("total_frac", 64'(want.frac),
                                    64'(result_if.total_frac));
                if (result_if.saturated !== want.sat)
                    report_mismatch("saturated", 64'(want.sat),
                                    64'(result_if.saturated));
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL decimal_text_sum_accumulator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random idling plus requested long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : sink_ready
        int unsigned hold_left;
        int unsigned hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_taken != hold_requests)
            begin
                hold_taken = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Text source
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back transactions need no gap.
    task automatic send_char(input logic [7:0] c, input logic ve, input logic se);
        while ($urandom_range(99) < source_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.ch        <= c;
        text_if.value_end <= ve;
        text_if.set_end   <= se;
        do
            @(posedge clk);
        while (!text_if.ready);
        predict_total(c, ve, se);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic ve, input logic se);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ve && (i == s.len() - 1), se && (i == s.len() - 1));
    endtask

    // Drop valid and hold off until every pending total has come back
    task automatic wait_totals_drained();
        text_if.valid <= 1'b0;
        while (totals_due.size() != 0)
            @(negedge clk);
    endtask

    // One random value; mostly well-formed, with noise and odd endings mixed in
    task automatic send_random_value(input logic closes_set);
        logic [7:0]  text_q[$];
        int unsigned kind;
        int unsigned pick;
        int unsigned nwhole;
        int unsigned nfrac;
        logic        drop_ve;
        string       big;
        kind = $urandom_range(99);
        if (kind < 5)
        begin
            // raw noise bytes
            repeat ($urandom_range(4, 1))
                text_q.push_back(8'($urandom_range(255)));
        end
        else if (kind < 9)
            text_q.push_back(8'h00);
        else
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                text_q.push_back(CH_MINUS);
            else if (pick == 1)
                text_q.push_back(CH_PLUS);
            if (kind < 13)
            begin
                // right at the top of the whole range
                big = $sformatf("%0d", WHOLE_LIMIT - 64'($urandom_range(2)));
                for (int i = 0; i < big.len(); i++)
                    text_q.push_back(big[i]);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    nwhole = $urandom_range(3);
                else if (pick < 80)
                    nwhole = $urandom_range(9, 4);
                else if (pick < 92)
                    nwhole = $urandom_range(14, 10);
                else
                    nwhole = $urandom_range(17, 15);
                repeat (nwhole)
                    text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(99) < 70)
            begin
                text_q.push_back(CH_POINT);
                pick  = $urandom_range(99);
                nfrac = (pick < 85) ? $urandom_range(10) : $urandom_range(12, 11);
                repeat (nfrac)
                    text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            // junk tail
            if ($urandom_range(99) < 10)
            begin
                case ($urandom_range(3))
                    0: text_q.push_back(CH_POINT);
                    1: text_q.push_back(CH_MINUS);
                    2: text_q.push_back(8'h00);
                    default: text_q.push_back(8'($urandom_range(255)));
                endcase
                text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            if (text_q.size() == 0)
                text_q.push_back(CH_ZERO);
        end
        drop_ve = closes_set && ($urandom_range(99) < 20);
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], (i == text_q.size() - 1) && !drop_ve,
                      (i == text_q.size() - 1) && closes_set);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Leading signs skipped, fraction carry into the whole part
    task automatic test_sign_and_carry();
        send_text("+9.5", 1'b1, 1'b0);
        send_text("-0.5", 1'b1, 1'b1);
        wait_totals_drained();
    endtask

    // NUL value, all-ones byte, parse stopped by a stray character
    task automatic test_null_and_junk();
        send_char(8'hFF, 1'b1, 1'b0);
        send_text("1x.5", 1'b1, 1'b1);
        send_char(8'h00, 1'b1, 1'b1);
        wait_totals_drained();
    endtask

    // Eleventh fraction digit dropped; set end closes the value on its own
    task automatic test_fraction_limit();
        send_text(".99999999999", 1'b0, 1'b1);
        wait_totals_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned src_pct,
                                       input int unsigned snk_pct);
        int unsigned first;
        source_idle_pct = src_pct;
        sink_idle_pct   = snk_pct;
        first           = items_sent;
        while (items_sent - first < n_items)
        begin
            int unsigned n_values;
            n_values = $urandom_range(4, 1);
            for (int unsigned k = 0; k < n_values; k++)
                send_random_value(k == n_values - 1);
        end
        wait_totals_drained();
    endtask

    // Sink holds off while one-character sets keep coming, so the input stalls
    task automatic test_output_stall();
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        hold_requests++;
        for (int k = 0; k < 30; k++)
            send_char(CH_ZERO + 8'(k % 10), 1'b1, 1'b1);
        wait_totals_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        text_if.valid     = 1'b0;
        text_if.ch        = '0;
        text_if.value_end = 1'b0;
        text_if.set_end   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        source_idle_pct = 25;
        sink_idle_pct   = 48;
        test_sign_and_carry();
        test_null_and_junk();
        test_fraction_limit();

        test_random_traffic(290, 25, 48);
        test_random_traffic(290, 48, 25);
        test_output_stall();
        test_random_traffic(290, 0, 0);

        wait_totals_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS decimal_text_sum_accumulator");
        else
            $display("FAIL decimal_text_sum_accumulator");
        $finish;
    end

endmodule

### sim.f
src/dtsa_pkg.sv
src/dtsa_if.sv
src/decimal_text_sum_accumulator.sv
test/testbench.sv
